// File: rtl/core/imu_gravity_velocity_projection_macros.svh
// Assertion helpers shared by the RTL of the gravity/velocity projection block.
`ifndef IMU_GRAVITY_VELOCITY_PROJECTION_MACROS_SVH
`define IMU_GRAVITY_VELOCITY_PROJECTION_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define IGVP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IGVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/igvp_pkg.sv
`timescale 1ns / 1ps

package igvp_pkg;

   localparam int QUAT_W   = 16;
   localparam int GRAV_W   = 16;
   localparam int THR_W    = 15;
   localparam int NUM_AXES = 3;
   localparam int NUM_PROD = 9;
   localparam int NUM_COEF = 9;

   localparam logic [THR_W-1:0] FALL_THR_RESET = 15'd29491;

   // quaternion product slots
   localparam int P_XX = 0;
   localparam int P_YY = 1;
   localparam int P_ZZ = 2;
   localparam int P_XY = 3;
   localparam int P_WZ = 4;
   localparam int P_XZ = 5;
   localparam int P_WY = 6;
   localparam int P_YZ = 7;
   localparam int P_WX = 8;

   // rotation matrix slots, row major
   localparam int R00 = 0;
   localparam int R01 = 1;
   localparam int R02 = 2;
   localparam int R10 = 3;
   localparam int R11 = 4;
   localparam int R12 = 5;
   localparam int R20 = 6;
   localparam int R21 = 7;
   localparam int R22 = 8;

   typedef logic signed [QUAT_W-1:0]   quat_type;
   typedef logic signed [2*QUAT_W-1:0] prod_type;
   typedef logic signed [GRAV_W-1:0]   grav_type;
   typedef logic [THR_W-1:0]           thr_type;

endpackage

// File: rtl/core/imu_gravity_velocity_projection.sv
// Rotates the world gravity direction (0,0,-1) and a world-frame velocity into the body frame
// with the conjugate of an IMU quaternion, and flags a fall when |grav_x| exceeds the
// programmed threshold. A word is taken at every clock edge where start is high and busy is
// low; busy is high only during reset, so one word can enter every cycle. Each result appears
// on the rsp_ ports for exactly one cycle with rsp_valid high, once its word has passed all
// five register stages; the receiver cannot stall, so capture it then. The stages are: the
// nine quaternion products, the wide matrix sums, coefficient round and clamp, the
// coefficient-by-velocity products with gravity saturation, and the velocity sums with the
// fall compare. Write the fall threshold (csr_wr_en, csr_wr_data) only while no word is in
// flight.
`timescale 1ns / 1ps

`include "imu_gravity_velocity_projection_macros.svh"

module imu_gravity_velocity_projection #(
   parameter int QUAT_FRAC_BITS = 15,
   parameter int VEL_WIDTH      = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // input words
   input  logic                               start,
   output logic                               busy,
   input  logic signed [igvp_pkg::QUAT_W-1:0] req_quat_w,
   input  logic signed [igvp_pkg::QUAT_W-1:0] req_quat_x,
   input  logic signed [igvp_pkg::QUAT_W-1:0] req_quat_y,
   input  logic signed [igvp_pkg::QUAT_W-1:0] req_quat_z,
   input  logic signed [VEL_WIDTH-1:0]        req_vel_x,
   input  logic signed [VEL_WIDTH-1:0]        req_vel_y,
   input  logic signed [VEL_WIDTH-1:0]        req_vel_z,
   // threshold register
   input  logic                               csr_wr_en,
   input  logic [igvp_pkg::THR_W-1:0]         csr_wr_data,
   // results
   output logic                               rsp_valid,
   output logic signed [igvp_pkg::GRAV_W-1:0] rsp_grav_x,
   output logic signed [igvp_pkg::GRAV_W-1:0] rsp_grav_y,
   output logic signed [igvp_pkg::GRAV_W-1:0] rsp_grav_z,
   output logic signed [VEL_WIDTH-1:0]        rsp_base_vel_x,
   output logic signed [VEL_WIDTH-1:0]        rsp_base_vel_y,
   output logic signed [VEL_WIDTH-1:0]        rsp_base_vel_z,
   output logic                               rsp_fallen
);
   import igvp_pkg::*;

   localparam int LATENCY = 5;
   // wide enough for 2^(2F) and for twice a sum of two 16x16 products
   localparam int WIDE_W  = (2*QUAT_FRAC_BITS + 3 > 35) ? 2*QUAT_FRAC_BITS + 3 : 35;
   localparam int CW      = QUAT_FRAC_BITS + 2;
   localparam int SAT_W   = (CW > GRAV_W) ? CW + 1 : GRAV_W + 1;

   typedef logic signed [WIDE_W-1:0]    wide_type;
   typedef logic signed [CW-1:0]        coef_type;
   typedef logic signed [SAT_W-1:0]     gsat_type;
   typedef logic signed [VEL_WIDTH-1:0] vel_type;
   typedef logic [GRAV_W:0]             mag_type;

   localparam wide_type ONE2      = wide_type'(1) <<< (2*QUAT_FRAC_BITS);
   localparam wide_type HALF_W    = wide_type'(2**(QUAT_FRAC_BITS-1));
   localparam wide_type ONE_W     = wide_type'(2**QUAT_FRAC_BITS);
   localparam wide_type NEG_ONE_W = -ONE_W;
   localparam coef_type ONE_C     = coef_type'(2**QUAT_FRAC_BITS);
   localparam coef_type NEG_ONE_C = -ONE_C;
   localparam gsat_type GRAV_HI   = gsat_type'(2**(GRAV_W-1) - 1);
   localparam gsat_type GRAV_LO   = -GRAV_HI - gsat_type'(1);

   logic     accept;
   logic     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   thr_type  thr_ff;

   prod_type s1_prod_ff  [NUM_PROD];
   prod_type s1_prod_in  [NUM_PROD];
   wide_type s2_wide_ff  [NUM_COEF];
   wide_type s2_wide_in  [NUM_COEF];
   coef_type s3_coef_ff  [NUM_COEF];
   coef_type s3_coef_in  [NUM_COEF];
   vel_type  s1_vel_ff   [NUM_AXES];
   vel_type  s2_vel_ff   [NUM_AXES];
   vel_type  s3_vel_ff   [NUM_AXES];
   grav_type s4_grav_ff  [NUM_AXES];
   grav_type s4_grav_in  [NUM_AXES];
   grav_type s5_grav_ff  [NUM_AXES];
   logic     s5_fallen_ff;
   logic     s5_fallen_in;
   mag_type  grav_x_mag;
   vel_type  lane_vel    [NUM_AXES];

   function automatic wide_type ext(input prod_type p);
      return wide_type'(p);
   endfunction

   // The pipeline never stalls; hold off new words only during reset.
   assign busy   = reset;
   assign accept = start && !busy;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= FALL_THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // valid bits travel alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // Stage 1: the nine quaternion products feeding R(q).
   always_comb begin
      s1_prod_in[P_XX] = prod_type'(req_quat_x) * prod_type'(req_quat_x);
      s1_prod_in[P_YY] = prod_type'(req_quat_y) * prod_type'(req_quat_y);
      s1_prod_in[P_ZZ] = prod_type'(req_quat_z) * prod_type'(req_quat_z);
      s1_prod_in[P_XY] = prod_type'(req_quat_x) * prod_type'(req_quat_y);
      s1_prod_in[P_WZ] = prod_type'(req_quat_w) * prod_type'(req_quat_z);
      s1_prod_in[P_XZ] = prod_type'(req_quat_x) * prod_type'(req_quat_z);
      s1_prod_in[P_WY] = prod_type'(req_quat_w) * prod_type'(req_quat_y);
      s1_prod_in[P_YZ] = prod_type'(req_quat_y) * prod_type'(req_quat_z);
      s1_prod_in[P_WX] = prod_type'(req_quat_w) * prod_type'(req_quat_x);
   end

   always_ff @(posedge clock) begin
      s1_prod_ff   <= s1_prod_in;
      s1_vel_ff[0] <= req_vel_x;
      s1_vel_ff[1] <= req_vel_y;
      s1_vel_ff[2] <= req_vel_z;
   end

   // Stage 2: matrix entries with 2F fraction bits.
   always_comb begin
      s2_wide_in[R00] = ONE2 - ((ext(s1_prod_ff[P_YY]) + ext(s1_prod_ff[P_ZZ])) <<< 1);
      s2_wide_in[R01] = (ext(s1_prod_ff[P_XY]) - ext(s1_prod_ff[P_WZ])) <<< 1;
      s2_wide_in[R02] = (ext(s1_prod_ff[P_XZ]) + ext(s1_prod_ff[P_WY])) <<< 1;
      s2_wide_in[R10] = (ext(s1_prod_ff[P_XY]) + ext(s1_prod_ff[P_WZ])) <<< 1;
      s2_wide_in[R11] = ONE2 - ((ext(s1_prod_ff[P_XX]) + ext(s1_prod_ff[P_ZZ])) <<< 1);
      s2_wide_in[R12] = (ext(s1_prod_ff[P_YZ]) - ext(s1_prod_ff[P_WX])) <<< 1;
      s2_wide_in[R20] = (ext(s1_prod_ff[P_XZ]) - ext(s1_prod_ff[P_WY])) <<< 1;
      s2_wide_in[R21] = (ext(s1_prod_ff[P_YZ]) + ext(s1_prod_ff[P_WX])) <<< 1;
      s2_wide_in[R22] = ONE2 - ((ext(s1_prod_ff[P_XX]) + ext(s1_prod_ff[P_YY])) <<< 1);
   end

   always_ff @(posedge clock) begin
      s2_wide_ff <= s2_wide_in;
      s2_vel_ff  <= s1_vel_ff;
   end

   // Stage 3: round half up to F fraction bits, clamp to [-1, +1].
   for (genvar k = 0; k < NUM_COEF; k++) begin : g_coef
      wide_type rounded;
      always_comb begin
         rounded = (s2_wide_ff[k] + HALF_W) >>> QUAT_FRAC_BITS;
         if (rounded > ONE_W) begin
            s3_coef_in[k] = ONE_C;
         end else if (rounded < NEG_ONE_W) begin
            s3_coef_in[k] = NEG_ONE_C;
         end else begin
            s3_coef_in[k] = coef_type'(rounded);
         end
      end
   end

   always_ff @(posedge clock) begin
      s3_coef_ff <= s3_coef_in;
      s3_vel_ff  <= s2_vel_ff;
   end

   // Stage 4: gravity is the negated third row, saturated to 16 bits.
   for (genvar i = 0; i < NUM_AXES; i++) begin : g_grav
      gsat_type neg;
      always_comb begin
         neg = -gsat_type'(s3_coef_ff[R20 + i]);
         if (neg > GRAV_HI) begin
            s4_grav_in[i] = grav_type'(GRAV_HI);
         end else if (neg < GRAV_LO) begin
            s4_grav_in[i] = grav_type'(GRAV_LO);
         end else begin
            s4_grav_in[i] = grav_type'(neg);
         end
      end
   end

   always_ff @(posedge clock) begin
      s4_grav_ff <= s4_grav_in;
   end

   // Stages 4 and 5 of the velocity: column i of R dotted with the world velocity.
   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      coef_type col [NUM_AXES];
      for (genvar j = 0; j < NUM_AXES; j++) begin : g_col
         assign col[j] = s3_coef_ff[j*NUM_AXES + i];
      end

      igvp_vel_lane #(
         .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
         .VEL_WIDTH      (VEL_WIDTH)
      ) u_lane (
         .clock    (clock),
         .coef     (col),
         .vel      (s3_vel_ff),
         .base_vel (lane_vel[i])
      );
   end

   // Stage 5: fall compare on the saturated grav_x; the most negative code always trips.
   always_comb begin
      if (s4_grav_ff[0][GRAV_W-1]) begin
         grav_x_mag = -mag_type'(s4_grav_ff[0]);
      end else begin
         grav_x_mag = mag_type'(s4_grav_ff[0]);
      end
      s5_fallen_in = grav_x_mag > mag_type'(thr_ff);
   end

   always_ff @(posedge clock) begin
      s5_grav_ff   <= s4_grav_ff;
      s5_fallen_ff <= s5_fallen_in;
   end

   assign rsp_valid      = s5_valid_ff;
   assign rsp_grav_x     = s5_grav_ff[0];
   assign rsp_grav_y     = s5_grav_ff[1];
   assign rsp_grav_z     = s5_grav_ff[2];
   assign rsp_base_vel_x = lane_vel[0];
   assign rsp_base_vel_y = lane_vel[1];
   assign rsp_base_vel_z = lane_vel[2];
   assign rsp_fallen     = s5_fallen_ff;

   // A result strobe only follows an accepted word.
   `IGVP_ASSERT_IMP(a_latency, clock, reset, rsp_valid, $past(accept, LATENCY), "result strobe without an accepted word")
   // Every word taken shows up as a result strobe.
   `IGVP_ASSERT_NEXT(a_strobe, clock, reset, accept, ##(LATENCY-1) rsp_valid, "accepted word produced no result")
   // A fall needs a nonzero gravity x component.
   `IGVP_ASSERT_IMP(a_fall_nonzero, clock, reset, rsp_valid && rsp_fallen, rsp_grav_x != '0, "fall flagged with zero grav_x")
   // A threshold write lands on the next edge.
   `IGVP_ASSERT_NEXT(a_thr_write, clock, reset, csr_wr_en, thr_ff == $past(csr_wr_data), "threshold write not taken")

endmodule

// File: rtl/core/igvp_vel_lane.sv
`timescale 1ns / 1ps

// One body-frame velocity axis: three products, then sum, round and saturate.
module igvp_vel_lane #(
   parameter int QUAT_FRAC_BITS = 15,
   parameter int VEL_WIDTH      = 16
) (
   input  logic                              clock,
   input  logic signed [QUAT_FRAC_BITS+1:0]  coef [igvp_pkg::NUM_AXES],
   input  logic signed [VEL_WIDTH-1:0]       vel  [igvp_pkg::NUM_AXES],
   output logic signed [VEL_WIDTH-1:0]       base_vel
);
   import igvp_pkg::*;

   localparam int CW = QUAT_FRAC_BITS + 2;
   localparam int PW = CW + VEL_WIDTH;
   localparam int SW = PW + 2;

   typedef logic signed [PW-1:0]        lane_prod_type;
   typedef logic signed [SW-1:0]        lane_sum_type;
   typedef logic signed [VEL_WIDTH-1:0] lane_vel_type;

   localparam lane_sum_type HALF   = lane_sum_type'(2**(QUAT_FRAC_BITS-1));
   localparam lane_sum_type VEL_HI = (lane_sum_type'(1) <<< (VEL_WIDTH-1)) - lane_sum_type'(1);
   localparam lane_sum_type VEL_LO = -VEL_HI - lane_sum_type'(1);

   lane_prod_type prod_ff [NUM_AXES];
   lane_prod_type prod_in [NUM_AXES];
   lane_sum_type  sum;
   lane_vel_type  base_vel_ff;
   lane_vel_type  base_vel_in;

   always_comb begin
      for (int j = 0; j < NUM_AXES; j++) begin
         prod_in[j] = lane_prod_type'(coef[j]) * lane_prod_type'(vel[j]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // round half up, then clamp to the velocity range
   always_comb begin
      sum = (lane_sum_type'(prod_ff[0]) + lane_sum_type'(prod_ff[1])
             + lane_sum_type'(prod_ff[2]) + HALF) >>> QUAT_FRAC_BITS;
      if (sum > VEL_HI) begin
         base_vel_in = lane_vel_type'(VEL_HI);
      end else if (sum < VEL_LO) begin
         base_vel_in = lane_vel_type'(VEL_LO);
      end else begin
         base_vel_in = lane_vel_type'(sum);
      end
   end

   always_ff @(posedge clock) begin
      base_vel_ff <= base_vel_in;
   end

   assign base_vel = base_vel_ff;

endmodule
